>>> rtl/rgb_led_pwm_serializer_macros.svh
`ifndef RGB_LED_PWM_SERIALIZER_MACROS_SVH
`define RGB_LED_PWM_SERIALIZER_MACROS_SVH

// checked out of reset
`define RLPS_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define RLPS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rlps_pkg.sv
package rlps_pkg;

  localparam int MAX_LEDS_DEF = 256;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  localparam logic [2:0] CFG_PERIOD   = 3'd0;
  localparam logic [2:0] CFG_ZERO_HI  = 3'd1;
  localparam logic [2:0] CFG_ONE_HI   = 3'd2;
  localparam logic [2:0] CFG_GAP      = 3'd3;
  localparam logic [2:0] CFG_LEDS     = 3'd4;

  typedef struct packed {
    logic [16:0] period_counts;
    logic [15:0] zero_high_counts;
    logic [15:0] one_high_counts;
    logic [15:0] gap_periods;
    logic [8:0]  leds_in_use;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        idx_ok;
    logic [15:0] led_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cmd_t;

  // LED count clamped to 1..max_leds
  function automatic logic [16:0] eff_leds(input logic [8:0] n, input logic [16:0] max_leds);
    logic [16:0] v;
    v = {8'd0, n};
    if (v == 17'd0) v = 17'd1;
    if (v > max_leds) v = max_leds;
    return v;
  endfunction

endpackage

>>> rtl/rlps_front.sv
module rlps_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic [16:0]   leds_eff,
  input  logic          clearing,
  output logic          q_valid,
  input  logic          q_ready,
  output rlps_pkg::cmd_t q_data
);
  import rlps_pkg::*;

  assign in_tready = q_ready & ~clearing;
  assign q_valid   = in_tvalid & ~clearing;

  always_comb begin
    q_data.mode      = in_tuser;
    q_data.led_index = in_tdata[15:0];
    q_data.red       = in_tdata[23:16];
    q_data.green     = in_tdata[31:24];
    q_data.blue      = in_tdata[39:32];
    q_data.idx_ok    = ({1'b0, in_tdata[15:0]} < leds_eff);
  end

endmodule

>>> rtl/rlps_queue.sv
module rlps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rlps_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rlps_pkg::cmd_t pop_data
);
  import rlps_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_r];
  assign push = push_valid & push_ready;
  assign pop  = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

endmodule

>>> rtl/rlps_engine.sv
module rlps_engine #(
  parameter int MAX_LEDS = rlps_pkg::MAX_LEDS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rlps_pkg::cfg_t cfg,
  input  logic [16:0]    leds_eff,
  input  logic           q_valid,
  output logic           q_ready,
  input  rlps_pkg::cmd_t q_data,
  output logic           clearing,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);
  import rlps_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_LEDS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FILL  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  // one row per LED: [7:0] green, [15:8] red, [23:16] blue
  logic [23:0] mem [MAX_LEDS];

  logic [1:0]    st_r, st_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [1:0]    color_r, color_nxt;
  logic [AW-1:0] led_r, led_nxt;
  logic [15:0]   gap_r, gap_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [23:0]   fill_r, fill_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [23:0]   rd_q_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [23:0]   mem_wd;

  logic [16:0] eff_p, pm1;
  logic [7:0]  cur_byte;
  logic [15:0] hsel, hi;
  logic        level, busy, pop, wrap, last_led, gap_end, done;
  logic [16:0] tick_inc, led_inc, gap_inc;
  logic [15:0] gp;

  always_comb begin
    eff_p = cfg.period_counts;
    if (eff_p < 17'd2) eff_p = 17'd2;
    if (eff_p > 17'h10000) eff_p = 17'h10000;
    pm1 = eff_p - 17'd1;
    case (color_r)
      2'd0:    cur_byte = rd_q_r[7:0];
      2'd1:    cur_byte = rd_q_r[15:8];
      default: cur_byte = rd_q_r[23:16];
    endcase
    hsel = cur_byte[bit_r] ? cfg.one_high_counts : cfg.zero_high_counts;
    hi   = ({1'b0, hsel} > pm1) ? pm1[15:0] : hsel;
    level = (phase_r == PH_DATA) && (tick_r < hi);
    busy  = (phase_r != PH_IDLE);
    tick_inc = {1'b0, tick_r} + 17'd1;
    wrap     = (tick_inc >= eff_p);
    led_inc  = 17'(led_r) + 17'd1;
    last_led = (led_inc >= leds_eff);
    gp       = (cfg.gap_periods == 16'd0) ? 16'd1 : cfg.gap_periods;
    gap_inc  = {1'b0, gap_r} + 17'd1;
    gap_end  = (gap_inc >= {1'b0, gp});
  end

  assign pop      = (st_r == ST_RUN) && q_valid && (!out_valid_r || out_tready);
  assign q_ready  = pop;
  assign clearing = (st_r == ST_CLEAR);

  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bit_nxt       = bit_r;
    color_nxt     = color_r;
    led_nxt       = led_r;
    gap_nxt       = gap_r;
    sweep_nxt     = sweep_r;
    fill_nxt      = fill_r;
    rd_addr_nxt   = rd_addr_r;
    mem_we        = 1'b0;
    mem_wa        = sweep_r;
    mem_wd        = fill_r;
    done          = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    case (st_r)
      ST_CLEAR, ST_FILL: begin
        mem_we    = 1'b1;
        mem_wd    = (st_r == ST_CLEAR) ? 24'd0 : fill_r;
        sweep_nxt = sweep_r + AW'(1);
        if (sweep_r == LAST_ROW) st_nxt = ST_RUN;
      end
      ST_LOAD: begin
        st_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (pop) begin
          case (q_data.mode)
            MODE_WRITE: begin
              if (!busy && q_data.idx_ok) begin
                mem_we = 1'b1;
                mem_wa = q_data.led_index[AW-1:0];
                mem_wd = {q_data.blue, q_data.red, q_data.green};
              end
            end
            MODE_FILL: begin
              if (!busy) begin
                fill_nxt  = {q_data.blue, q_data.red, q_data.green};
                sweep_nxt = '0;
                st_nxt    = ST_FILL;
              end
            end
            MODE_START: begin
              if (!busy) begin
                phase_nxt   = PH_DATA;
                tick_nxt    = 16'd0;
                bit_nxt     = 3'd7;
                color_nxt   = 2'd0;
                led_nxt     = '0;
                gap_nxt     = 16'd0;
                rd_addr_nxt = '0;
                st_nxt      = ST_LOAD;
              end
            end
            MODE_TICK: begin
              if (busy) begin
                tick_nxt = wrap ? 16'd0 : tick_inc[15:0];
                if (wrap && phase_r == PH_DATA) begin
                  if (bit_r == 3'd0) begin
                    bit_nxt = 3'd7;
                    if (color_r != 2'd2) begin
                      color_nxt = color_r + 2'd1;
                    end else if (last_led) begin
                      phase_nxt = PH_GAP;
                      gap_nxt   = 16'd0;
                    end else begin
                      color_nxt   = 2'd0;
                      led_nxt     = led_inc[AW-1:0];
                      rd_addr_nxt = led_inc[AW-1:0];
                      st_nxt      = ST_LOAD;
                    end
                  end else begin
                    bit_nxt = bit_r - 3'd1;
                  end
                end else if (wrap && phase_r == PH_GAP) begin
                  gap_nxt = gap_inc[15:0];
                  if (gap_end) begin
                    phase_nxt = PH_IDLE;
                    gap_nxt   = 16'd0;
                    done      = 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, (phase_nxt != PH_IDLE), level};
          out_last_nxt  = done;
        end
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      phase_r     <= PH_IDLE;
      tick_r      <= 16'd0;
      bit_r       <= 3'd7;
      color_r     <= 2'd0;
      led_r       <= '0;
      gap_r       <= 16'd0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bit_r       <= bit_nxt;
      color_r     <= color_nxt;
      led_r       <= led_nxt;
      gap_r       <= gap_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r     <= fill_nxt;
    rd_addr_r  <= rd_addr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q_r <= mem[rd_addr_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/rgb_led_pwm_serializer.sv
// Single-wire NRZ serialiser for a chain of addressable RGB LEDs, GRB byte order.
// Input channel: one request per command; in_tuser is the mode (write one LED,
// fill all, start frame, timer tick), in_tdata carries index and colour bytes.
// Output channel: one result per request: line level before the request, busy
// after it, and tlast on the tick that closes the latch gap.
// Configuration: cfg_we with cfg_index/cfg_wdata, only while the block is idle.
// A decoder and a two-entry queue take requests; the engine runs one request a
// cycle unless the output or engine stalls, so ticks go through at one per cycle.
// Stalls: a fill sweeps every row of the pixel memory; a frame start and each
// move to the next LED's row stall for the memory read.
// After reset every memory row is cleared in turn with in_tready low;
// configuration writes are taken throughout.
// A stalled output holds its result; up to two further requests queue, then
// in_tready drops.
module rgb_led_pwm_serializer #(
  parameter int MAX_LEDS = rlps_pkg::MAX_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // led_index[15:0], red, green, blue
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // line_level, busy_res, zero pad
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);
  import rlps_pkg::*;

  cfg_t        cfg_r;
  logic [16:0] leds_eff;
  logic        q_in_valid, q_in_ready, q_out_valid, q_out_ready, clearing;
  cmd_t        q_in_data, q_out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_counts    <= 17'd125;
      cfg_r.zero_high_counts <= 16'd40;
      cfg_r.one_high_counts  <= 16'd80;
      cfg_r.gap_periods      <= 16'd84;
      cfg_r.leds_in_use      <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:  cfg_r.period_counts    <= cfg_wdata;
        CFG_ZERO_HI: cfg_r.zero_high_counts <= cfg_wdata[15:0];
        CFG_ONE_HI:  cfg_r.one_high_counts  <= cfg_wdata[15:0];
        CFG_GAP:     cfg_r.gap_periods      <= cfg_wdata[15:0];
        CFG_LEDS:    cfg_r.leds_in_use      <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign leds_eff = eff_leds(cfg_r.leds_in_use, 17'(MAX_LEDS));

  rlps_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .leds_eff  (leds_eff),
    .clearing  (clearing),
    .q_valid   (q_in_valid),
    .q_ready   (q_in_ready),
    .q_data    (q_in_data)
  );

  rlps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  rlps_engine #(
    .MAX_LEDS (MAX_LEDS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .leds_eff   (leds_eff),
    .q_valid    (q_out_valid),
    .q_ready    (q_out_ready),
    .q_data     (q_out_data),
    .clearing   (clearing),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/rlps_checker.sv
`include "rgb_led_pwm_serializer_macros.svh"

module rlps_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  `RLPS_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  // frame end leaves the block idle
  `RLPS_ASSERT_RUN(a_done_idle, out_tvalid && out_tlast |-> !out_tdata[1], "done while busy")
  // a high line only comes from data phase, which is still busy afterwards
  `RLPS_ASSERT_RUN(a_high_busy, out_tvalid && out_tdata[0] |-> out_tdata[1], "line high while idle")
  // memory clear follows reset
  `RLPS_ASSERT_ANY(a_reset_quiet, !rst_n |=> !in_tready && !out_tvalid, "active after reset")

endmodule

bind rgb_led_pwm_serializer rlps_checker u_rlps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> sim/rgb_led_pwm_serializer_tb.sv
`timescale 1ns / 100ps

module rgb_led_pwm_serializer_tb;
  import rlps_pkg::*;

  typedef enum logic [1:0] {LINE_IDLE, LINE_DATA, LINE_GAP} line_phase_t;

  typedef struct packed {
    logic level;
    logic busy;
    logic done;
  } line_sample_t;

  class nrz_line_predictor_t;
    bit [16:0] period_reg;
    bit [15:0] zero_hi_reg;
    bit [15:0] one_hi_reg;
    bit [15:0] gap_reg;
    bit [8:0]  leds_reg;
    bit [7:0]  pixels [3*MAX_LEDS_DEF];
    int unsigned tick_cnt;
    int unsigned bit_pos;
    int unsigned byte_pos;
    int unsigned gap_cnt;
    line_phase_t phase;
    bit [7:0] cur_byte;
    line_sample_t line_due [$];
    int unsigned mismatches;

    function new();
      period_reg  = 17'd125;
      zero_hi_reg = 16'd40;
      one_hi_reg  = 16'd80;
      gap_reg     = 16'd84;
      leds_reg    = 9'd256;
      foreach (pixels[i]) pixels[i] = 8'h00;
      tick_cnt   = 0;
      bit_pos    = 7;
      byte_pos   = 0;
      gap_cnt    = 0;
      phase      = LINE_IDLE;
      cur_byte   = 8'h00;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [16:0] value);
      case (index)
        CFG_PERIOD:  period_reg  = value;
        CFG_ZERO_HI: zero_hi_reg = value[15:0];
        CFG_ONE_HI:  one_hi_reg  = value[15:0];
        CFG_GAP:     gap_reg     = value[15:0];
        CFG_LEDS:    leds_reg    = value[8:0];
        default: ;
      endcase
    endfunction

    function int unsigned period_eff();
      int unsigned p;
      p = 32'(period_reg);
      if (p < 2) p = 2;
      if (p > 65536) p = 65536;
      return p;
    endfunction

    function int unsigned leds_eff();
      int unsigned n;
      n = 32'(leds_reg);
      if (n < 1) n = 1;
      if (n > MAX_LEDS_DEF) n = MAX_LEDS_DEF;
      return n;
    endfunction

    function bit level_now();
      int unsigned h;
      if (phase != LINE_DATA) return 1'b0;
      h = cur_byte[bit_pos] ? 32'(one_hi_reg) : 32'(zero_hi_reg);
      if (h > period_eff() - 1) h = period_eff() - 1;
      return tick_cnt < h;
    endfunction

    function void take_command(logic [1:0] mode, logic [15:0] idx,
                               logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      line_sample_t s;
      bit was_busy;
      bit wrap;
      int unsigned gp;
      int unsigned row;
      s.level  = level_now();
      s.done   = 1'b0;
      was_busy = (phase != LINE_IDLE);
      row      = 32'(idx);
      case (mode)
        MODE_WRITE: begin
          if (!was_busy && row < leds_eff()) begin
            pixels[row*3]     = green;
            pixels[row*3 + 1] = red;
            pixels[row*3 + 2] = blue;
          end
        end
        MODE_FILL: begin
          if (!was_busy) begin
            for (int i = 0; i < MAX_LEDS_DEF; i++) begin
              pixels[i*3]     = green;
              pixels[i*3 + 1] = red;
              pixels[i*3 + 2] = blue;
            end
          end
        end
        MODE_START: begin
          if (!was_busy) begin
            phase    = LINE_DATA;
            tick_cnt = 0;
            bit_pos  = 7;
            byte_pos = 0;
            gap_cnt  = 0;
            cur_byte = pixels[0];
          end
        end
        MODE_TICK: begin
          if (was_busy) begin
            wrap     = (tick_cnt + 1 >= period_eff());
            tick_cnt = wrap ? 0 : tick_cnt + 1;
            if (wrap && phase == LINE_DATA) begin
              if (bit_pos == 0) begin
                bit_pos = 7;
                byte_pos++;
                if (byte_pos >= leds_eff() * 3) begin
                  phase   = LINE_GAP;
                  gap_cnt = 0;
                end else begin
                  cur_byte = pixels[byte_pos];
                end
              end else begin
                bit_pos--;
              end
            end else if (wrap && phase == LINE_GAP) begin
              gp = (gap_reg != 0) ? 32'(gap_reg) : 1;
              gap_cnt++;
              if (gap_cnt >= gp) begin
                phase    = LINE_IDLE;
                gap_cnt  = 0;
                byte_pos = 0;
                s.done   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      s.busy = (phase != LINE_IDLE);
      line_due.push_back(s);
    endfunction

    function void check_line(logic level, logic busy, logic done);
      line_sample_t want;
      if (line_due.size() == 0) begin
        $error("result with nothing pending: line_level %0b busy_res %0b frame_done %0b",
               level, busy, done);
        mismatches++;
        return;
      end
      want = line_due.pop_front();
      if (level !== want.level) begin
        $error("line_level: expected %0b, actual %0b", want.level, level);
        mismatches++;
      end
      if (busy !== want.busy) begin
        $error("busy_res: expected %0b, actual %0b", want.busy, busy);
        mismatches++;
      end
      if (done !== want.done) begin
        $error("frame_done: expected %0b, actual %0b", want.done, done);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // led_index[15:0], red, green, blue
  logic [1:0]  in_tuser   = '0;   // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // line_level, busy_res, zero pad
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [16:0] cfg_wdata  = '0;

  nrz_line_predictor_t pred;
  int unsigned cmds_sent  = 0;
  int unsigned burst_left = 1;
  bit          tx_calm    = 1'b0;

  int unsigned rx_style = 0;
  int unsigned rx_left  = 0;
  int unsigned rx_ctr   = 0;

  rgb_led_pwm_serializer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: always ready, random stalls, or a fixed stall cadence
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_left  = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    rx_ctr++;
    case (rx_style)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ((rx_ctr % 16) < 11);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      pred.check_line(out_tdata[0], out_tdata[1], out_tlast);
  end

  task automatic send_cmd(input logic [1:0] mode, input logic [15:0] idx,
                          input logic [7:0] red, input logic [7:0] green,
                          input logic [7:0] blue);
    int unsigned pause;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {blue, green, red, idx};
    do @(posedge clk); while (!in_tready);
    pred.take_command(mode, idx, red, green, blue);
    cmds_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause = tx_calm ? 0 : $urandom_range(0, 6);
      if (pause != 0) begin
        in_tvalid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
  endtask

  task automatic send_tick();
    send_cmd(MODE_TICK, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_write();
    int unsigned idx;
    if ($urandom_range(0, 6) == 0) idx = $urandom_range(0, 65535);
    else idx = $urandom_range(0, pred.leds_eff() - 1);
    send_cmd(MODE_WRITE, 16'(idx), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_cmd(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom));
  endtask

  // ticks the frame out; noise_pct percent of the requests are random commands
  task automatic tick_to_idle(input int unsigned noise_pct);
    while (pred.phase != LINE_IDLE) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise();
      else send_tick();
    end
  endtask

  task automatic run_frame(input int unsigned noise_pct);
    send_cmd(MODE_START, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    tick_to_idle(noise_pct);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pred.line_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [16:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    pred.set_reg(index, value);
  endtask

  task automatic apply_setting(input logic [16:0] per, input logic [16:0] zero_hi,
                               input logic [16:0] one_hi, input logic [16:0] gap,
                               input logic [16:0] leds);
    write_reg(CFG_PERIOD, per);
    write_reg(CFG_ZERO_HI, zero_hi);
    write_reg(CFG_ONE_HI, one_hi);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_LEDS, leds);
    cfg_we <= 1'b0;
  endtask

  task automatic random_setting();
    logic [16:0] per, zero_hi, one_hi, gap, leds;
    per     = 17'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5));
    zero_hi = 17'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 6));
    one_hi  = 17'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 6));
    gap     = 17'($urandom_range(0, 3));
    leds    = 17'(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
    apply_setting(per, zero_hi, one_hi, gap, leds);
  endtask

  task automatic random_session();
    repeat ($urandom_range(0, 6)) send_write();
    if ($urandom_range(0, 3) == 0)
      send_cmd(MODE_FILL, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 4)) send_tick();
    if ($urandom_range(0, 5) != 0) begin
      run_frame(8);
    end else begin
      repeat ($urandom_range(5, 30)) send_noise();
      tick_to_idle(0);
    end
  endtask

  initial begin
    pred = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: last LED in range, first one past it, idle tick
    send_cmd(MODE_WRITE, 16'd255, 8'h00, 8'hFF, 8'hFF);
    send_cmd(MODE_WRITE, 16'd256, 8'hFF, 8'h00, 8'h00);
    send_tick();
    settle();

    // registers past their limits: period 2, one-high clamped, gap 1, one LED
    apply_setting(17'd1, 17'd0, 17'd65535, 17'd0, 17'd0);
    send_cmd(MODE_WRITE, 16'd0, 8'hFF, 8'hA5, 8'h00);
    send_cmd(MODE_WRITE, 16'd1, 8'h12, 8'h34, 8'h56);
    send_cmd(MODE_WRITE, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    send_cmd(MODE_START, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_cmd(MODE_START, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(MODE_WRITE, 16'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(MODE_FILL, 16'd0, 8'h00, 8'h00, 8'h00);
    tick_to_idle(0);
    send_tick();
    send_cmd(MODE_FILL, 16'hFFFF, 8'hFF, 8'h00, 8'h5A);
    run_frame(0);
    settle();

    apply_setting(17'd4, 17'd1, 17'd3, 17'd2, 17'd2);
    run_frame(0);
    settle();

    while (cmds_sent < 550) begin
      if ($urandom_range(0, 3) != 0) random_setting();
      random_session();
      settle();
    end

    // longer latch gap, shortest period, sender without pauses
    tx_calm = 1'b1;
    apply_setting(17'd2, 17'd1, 17'd65535, 17'd100, 17'd1);
    send_write();
    run_frame(0);
    settle();

    // longest period, high counts at their ceiling; left running
    apply_setting(17'd131071, 17'd65535, 17'd65535, 17'd1, 17'd1);
    send_cmd(MODE_WRITE, 16'd0, 8'h0F, 8'hF0, 8'h3C);
    send_cmd(MODE_START, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_noise();
    repeat (300) send_tick();

    in_tvalid <= 1'b0;
    while (pred.line_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pred.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
